[hw/rtl/mkpd_pkg.sv]
// Shared constants for the matrix keypad scanner with counter debounce:
// key bit positions, field widths, register indexes and reset values.
// No dependencies.
`default_nettype none

package mkpd_pkg;

    // Field widths
    localparam int unsigned COL_W    = 4;
    localparam int unsigned ROW_W    = 4;
    localparam int unsigned ROW_IDX_W = 2;
    localparam int unsigned KEY_W    = 8;
    localparam int unsigned MAT_W    = 6;
    localparam int unsigned SETTLE_W = 10;
    localparam int unsigned THR_W    = 4;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 10;
    localparam int unsigned IN_TDATA_W = 8;
    localparam int unsigned OUT_TDATA_W = 16;

    // Debounced key bit positions
    localparam int unsigned KEY_UP    = 0;
    localparam int unsigned KEY_DOWN  = 1;
    localparam int unsigned KEY_LEFT  = 2;
    localparam int unsigned KEY_RIGHT = 3;
    localparam int unsigned KEY_OK    = 4;
    localparam int unsigned KEY_BACK  = 5;
    localparam int unsigned KEY_ENC   = 6;
    localparam int unsigned KEY_ID    = 7;

    // Row codes
    localparam logic [ROW_IDX_W-1:0] ROW_0 = 2'd0;
    localparam logic [ROW_IDX_W-1:0] ROW_1 = 2'd1;
    localparam logic [ROW_IDX_W-1:0] ROW_2 = 2'd2;
    localparam logic [ROW_IDX_W-1:0] ROW_3 = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE_THR   = 2'd1;

    // Register reset values
    localparam logic [SETTLE_W-1:0] SETTLE_RST = 10'd200;
    localparam logic [THR_W-1:0]    THR_RST    = 4'd3;

    typedef logic [THR_W-1:0] t_stable_cnt;

endpackage

`default_nettype wire

[hw/rtl/matrix_keypad_scan_debounce.sv]
// A result item is registered in the output register when its input item is accepted.
// Throughput: one item per cycle unless the sink stalls; the output register lets the next item in
// while the current result is being taken.
// Reset: synchronous active-low i_rst_n clears scan position, settle counter,
// matrix and debounce state, and loads settle_ticks=200, stable_threshold=3.
// Top level of the keypad scanner: row drive, column sampling and debounce.
// Depends on mkpd_pkg.
`default_nettype none

module matrix_keypad_scan_debounce (
    input  wire logic i_clk,
    input  wire logic i_rst_n,

    // Tick input: [3:0] column_levels, [4] encoder_switch_level, [5] id_level
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [mkpd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,

    // Result: [3:0] row_drive, [11:4] debounced_keys; tlast is scan_done
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic [mkpd_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
    output logic                                      m_axis_tlast,

    // Configuration write channel
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [mkpd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [mkpd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    // Configuration registers
    logic [mkpd_pkg::SETTLE_W-1:0] r_settle_ticks;
    logic [mkpd_pkg::THR_W-1:0]    r_stable_thr;

    // Scan and debounce state
    logic [mkpd_pkg::ROW_IDX_W-1:0] r_row_idx,      n_row_idx;
    logic [mkpd_pkg::SETTLE_W-1:0]  r_settle_cnt,   n_settle_cnt;
    logic [mkpd_pkg::MAT_W-1:0]     r_matrix,       n_matrix;
    logic [mkpd_pkg::KEY_W-1:0]     r_last_raw,     n_last_raw;
    logic [mkpd_pkg::KEY_W-1:0]     r_debounced,    n_debounced;
    mkpd_pkg::t_stable_cnt          r_stable_cnt [mkpd_pkg::KEY_W];
    mkpd_pkg::t_stable_cnt          n_stable_cnt [mkpd_pkg::KEY_W];

    // Output register
    logic                            r_out_valid;
    logic [mkpd_pkg::ROW_W-1:0]      r_out_row;
    logic [mkpd_pkg::KEY_W-1:0]      r_out_keys;
    logic                            r_out_done;

    logic                            in_accept;
    logic [mkpd_pkg::COL_W-1:0]      pressed;
    logic                            enc_level;
    logic                            id_level;
    logic [mkpd_pkg::KEY_W-1:0]      raw;
    logic [mkpd_pkg::ROW_W-1:0]      row_drive;
    logic                            scan_done;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign pressed   = ~s_axis_tdata[mkpd_pkg::COL_W-1:0];
    assign enc_level = s_axis_tdata[mkpd_pkg::COL_W];
    assign id_level  = s_axis_tdata[mkpd_pkg::COL_W+1];
    assign row_drive = ~(mkpd_pkg::ROW_W'(1) << r_row_idx);

    // Compute next scan state and debounce for one tick
    always_comb begin
        n_row_idx    = r_row_idx;
        n_settle_cnt = r_settle_cnt;
        n_matrix     = r_matrix;
        n_last_raw   = r_last_raw;
        n_debounced  = r_debounced;
        n_stable_cnt = r_stable_cnt;
        scan_done    = 1'b0;
        raw          = '0;

        if (r_settle_cnt < r_settle_ticks) begin
            n_settle_cnt = r_settle_cnt + 1'b1;
        end else begin
            n_settle_cnt = '0;
            n_row_idx    = r_row_idx + 1'b1;
            unique case (r_row_idx)
                mkpd_pkg::ROW_0: begin
                    n_matrix = '0;
                    n_matrix[mkpd_pkg::KEY_UP]   = pressed[0];
                    n_matrix[mkpd_pkg::KEY_LEFT] = pressed[3];
                end
                mkpd_pkg::ROW_1: begin
                    n_matrix[mkpd_pkg::KEY_OK] = r_matrix[mkpd_pkg::KEY_OK] | pressed[1];
                end
                mkpd_pkg::ROW_2: begin
                    n_matrix[mkpd_pkg::KEY_BACK] = r_matrix[mkpd_pkg::KEY_BACK] | pressed[2];
                end
                default: begin
                    n_matrix[mkpd_pkg::KEY_DOWN] =
                        r_matrix[mkpd_pkg::KEY_DOWN] | pressed[0];
                    n_matrix[mkpd_pkg::KEY_RIGHT] =
                        r_matrix[mkpd_pkg::KEY_RIGHT] | pressed[3];
                    raw[mkpd_pkg::MAT_W-1:0] = n_matrix;
                    raw[mkpd_pkg::KEY_ENC]   = !enc_level;
                    raw[mkpd_pkg::KEY_ID]    = !id_level;
                    scan_done = 1'b1;
                    // Per-key counter debounce, lanes are independent
                    for (int i = 0; i < mkpd_pkg::KEY_W; i++) begin
                        if (raw[i] == r_last_raw[i]) begin
                            if (r_stable_cnt[i] < r_stable_thr) begin
                                n_stable_cnt[i] = r_stable_cnt[i] + 1'b1;
                            end
                        end else begin
                            n_stable_cnt[i] = '0;
                        end
                        if (n_stable_cnt[i] >= r_stable_thr) begin
                            n_debounced[i] = raw[i];
                        end
                    end
                    n_last_raw = raw;
                end
            endcase
        end
    end

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle_ticks <= mkpd_pkg::SETTLE_RST;
            r_stable_thr   <= mkpd_pkg::THR_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == mkpd_pkg::CFG_SETTLE_TICKS) begin
                r_settle_ticks <= i_cfg_data;
            end else if (i_cfg_index == mkpd_pkg::CFG_STABLE_THR) begin
                r_stable_thr <= i_cfg_data[mkpd_pkg::THR_W-1:0];
            end
        end
    end

    // Advance scan state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_idx    <= '0;
            r_settle_cnt <= '0;
            r_matrix     <= '0;
            r_last_raw   <= '0;
            r_debounced  <= '0;
            for (int i = 0; i < mkpd_pkg::KEY_W; i++) begin
                r_stable_cnt[i] <= '0;
            end
        end else if (in_accept) begin
            r_row_idx    <= n_row_idx;
            r_settle_cnt <= n_settle_cnt;
            r_matrix     <= n_matrix;
            r_last_raw   <= n_last_raw;
            r_debounced  <= n_debounced;
            r_stable_cnt <= n_stable_cnt;
        end
    end

    // Hold the result item until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_row  <= row_drive;
            r_out_keys <= n_debounced;
            r_out_done <= scan_done;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {
        {(mkpd_pkg::OUT_TDATA_W - mkpd_pkg::KEY_W - mkpd_pkg::ROW_W){1'b0}},
        r_out_keys, r_out_row
    };
    assign m_axis_tlast  = r_out_done;

endmodule

`default_nettype wire
